FILE: rtl/core/nps_pkg.sv
// shared types and codes for the non-preemptive priority scheduler
// no dependencies; imported by nps_cell and the top level
package nps_pkg;

  localparam int ID_W    = 8;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int OUT_W   = 32;

  localparam logic MODE_ARRIVE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_DROP = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } job_t;

  typedef struct packed {
    logic wr_en;
    logic shift_en;
    logic valid;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_COMMIT = 4'b0100,
    ST_FIN    = 4'b1000
  } sched_st_t;

endpackage

FILE: rtl/core/nps_cell.sv
// one ready-queue slot: holds a job, shifts from its upper neighbor and
// passes the best-priority token down the chain; depends on nps_pkg
module nps_cell #(
  parameter int TIME_WIDTH = 32,
  parameter int IDX_W      = 4,
  parameter int CELL_IDX   = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  nps_pkg::cell_ctl_t     ctl,
  input  nps_pkg::job_t          wr_job,
  input  logic [TIME_WIDTH-1:0]  wr_arr,
  input  nps_pkg::job_t          nxt_job,
  input  logic [TIME_WIDTH-1:0]  nxt_arr,
  input  logic                   tok_in_vld,
  input  logic [nps_pkg::PRIO_W-1:0] tok_in_prio,
  input  logic [IDX_W-1:0]       tok_in_idx,
  output logic                   tok_out_vld,
  output logic [nps_pkg::PRIO_W-1:0] tok_out_prio,
  output logic [IDX_W-1:0]       tok_out_idx,
  output nps_pkg::job_t          job_out,
  output logic [TIME_WIDTH-1:0]  arr_out
);
  import nps_pkg::*;

  job_t                  job_r;
  logic [TIME_WIDTH-1:0] arr_r;
  logic                  tok_vld_r;
  logic [PRIO_W-1:0]     tok_prio_r;
  logic [IDX_W-1:0]      tok_idx_r;
  logic                  take_own;

  // strict compare keeps the earlier slot on equal priority
  assign take_own = ctl.valid && (!tok_in_vld || (job_r.prio < tok_in_prio));

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      job_r <= wr_job;
      arr_r <= wr_arr;
    end else if (ctl.shift_en) begin
      job_r <= nxt_job;
      arr_r <= nxt_arr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= take_own || tok_in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (take_own) begin
      tok_prio_r <= job_r.prio;
      tok_idx_r  <= IDX_W'(CELL_IDX);
    end else begin
      tok_prio_r <= tok_in_prio;
      tok_idx_r  <= tok_in_idx;
    end
  end

  assign tok_out_vld  = tok_vld_r;
  assign tok_out_prio = tok_prio_r;
  assign tok_out_idx  = tok_idx_r;
  assign job_out      = job_r;
  assign arr_out      = arr_r;

endmodule

FILE: rtl/core/nonpreemptive_priority_scheduler.sv
// top level of the non-preemptive priority scheduler: sequencer, run state,
// result staging and the chain of nps_cell queue slots; depends on nps_pkg
// An arrival beat writes the job into the next free slot (or reports a drop when
// all QUEUE_DEPTH slots are taken) and passes through FIN. A tick beat retires
// the running job when its burst has elapsed; a tick that leaves no job to start
// also passes through FIN. A tick that starts a job runs SCAN, COMMIT and FIN:
// the best-priority token travels down the slot chain one cell per cycle, then the
// winner is loaded and the slots above it shift down by one. One beat is in
// work at a time; a finished result waits in the output register while the next
// beat is taken. Queue slots need no clearing pass after reset, since only
// occupied slots are ever compared or read.
module nonpreemptive_priority_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [nps_pkg::ID_W-1:0]    in_job_id,
  input  logic [nps_pkg::BURST_W-1:0] in_burst_length,
  input  logic [nps_pkg::PRIO_W-1:0]  in_job_priority,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic [nps_pkg::ID_W-1:0]    out_done_id,
  output logic [nps_pkg::OUT_W-1:0]   out_finish_time,
  output logic [nps_pkg::OUT_W-1:0]   out_turnaround,
  output logic [nps_pkg::OUT_W-1:0]   out_wait_ticks
);
  import nps_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TW    = TIME_WIDTH;

  sched_st_t          st_r, st_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TW-1:0]      time_r, time_nxt;
  logic               running_r, running_nxt;
  logic [ID_W-1:0]    run_id_r, run_id_nxt;
  logic [BURST_W-1:0] run_burst_r, run_burst_nxt;
  logic [TW-1:0]      run_wait_r, run_wait_nxt;
  logic [TW-1:0]      run_end_r, run_end_nxt;
  logic [IDX_W-1:0]   scan_cnt_r, scan_cnt_nxt;

  logic               res_pend_r, res_pend_nxt;
  logic               res_kind_r, res_kind_nxt;
  logic [ID_W-1:0]    res_id_r, res_id_nxt;
  logic [TW-1:0]      res_fin_r, res_fin_nxt;
  logic [TW-1:0]      res_ta_r, res_ta_nxt;
  logic [TW-1:0]      res_wt_r, res_wt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  logic [OUT_W-1:0]   out_fin_r, out_fin_nxt;
  logic [OUT_W-1:0]   out_ta_r, out_ta_nxt;
  logic [OUT_W-1:0]   out_wt_r, out_wt_nxt;

  cell_ctl_t          ctl [QUEUE_DEPTH];
  job_t               cell_job [QUEUE_DEPTH];
  logic [TW-1:0]      cell_arr [QUEUE_DEPTH];
  job_t               nxt_job [QUEUE_DEPTH];
  logic [TW-1:0]      nxt_arr [QUEUE_DEPTH];
  logic               tok_vld [QUEUE_DEPTH];
  logic [PRIO_W-1:0]  tok_prio [QUEUE_DEPTH];
  logic [IDX_W-1:0]   tok_idx [QUEUE_DEPTH];
  logic               tin_vld [QUEUE_DEPTH];
  logic [PRIO_W-1:0]  tin_prio [QUEUE_DEPTH];
  logic [IDX_W-1:0]   tin_idx [QUEUE_DEPTH];

  job_t               wr_job;
  logic               in_acc;
  logic               q_full;
  logic               run_done;
  logic               out_free;
  logic [IDX_W-1:0]   best_idx;
  job_t               best_job;
  logic [TW-1:0]      best_arr;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (st_r == ST_IDLE);
  assign q_full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign run_done = running_r && (time_r == run_end_r);
  assign out_free = !out_valid_r || out_ready;

  // a zero burst runs for one tick
  assign wr_job.id    = in_job_id;
  assign wr_job.burst = (in_burst_length == '0) ? BURST_W'(1) : in_burst_length;
  assign wr_job.prio  = in_job_priority;

  assign best_idx = tok_idx[QUEUE_DEPTH-1];
  assign best_job = cell_job[best_idx];
  assign best_arr = cell_arr[best_idx];

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign tin_vld[gi]  = 1'b0;
        assign tin_prio[gi] = '0;
        assign tin_idx[gi]  = '0;
      end else begin : g_body
        assign tin_vld[gi]  = tok_vld[gi-1];
        assign tin_prio[gi] = tok_prio[gi-1];
        assign tin_idx[gi]  = tok_idx[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign nxt_job[gi] = cell_job[gi];
        assign nxt_arr[gi] = cell_arr[gi];
      end else begin : g_link
        assign nxt_job[gi] = cell_job[gi+1];
        assign nxt_arr[gi] = cell_arr[gi+1];
      end

      nps_cell #(
        .TIME_WIDTH (TW),
        .IDX_W      (IDX_W),
        .CELL_IDX   (gi)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl[gi]),
        .wr_job       (wr_job),
        .wr_arr       (time_r),
        .nxt_job      (nxt_job[gi]),
        .nxt_arr      (nxt_arr[gi]),
        .tok_in_vld   (tin_vld[gi]),
        .tok_in_prio  (tin_prio[gi]),
        .tok_in_idx   (tin_idx[gi]),
        .tok_out_vld  (tok_vld[gi]),
        .tok_out_prio (tok_prio[gi]),
        .tok_out_idx  (tok_idx[gi]),
        .job_out      (cell_job[gi]),
        .arr_out      (cell_arr[gi])
      );
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ctl[i].valid    = (CNT_W'(i) < count_r);
      ctl[i].wr_en    = in_acc && (in_mode == MODE_ARRIVE) && !q_full &&
                        (count_r == CNT_W'(i));
      ctl[i].shift_en = (st_r == ST_COMMIT) && (IDX_W'(i) >= best_idx);
    end
  end

  always_comb begin
    st_nxt        = st_r;
    count_nxt     = count_r;
    time_nxt      = time_r;
    running_nxt   = running_r;
    run_id_nxt    = run_id_r;
    run_burst_nxt = run_burst_r;
    run_wait_nxt  = run_wait_r;
    run_end_nxt   = run_end_r;
    scan_cnt_nxt  = scan_cnt_r;
    res_pend_nxt  = res_pend_r;
    res_kind_nxt  = res_kind_r;
    res_id_nxt    = res_id_r;
    res_fin_nxt   = res_fin_r;
    res_ta_nxt    = res_ta_r;
    res_wt_nxt    = res_wt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_fin_nxt   = out_fin_r;
    out_ta_nxt    = out_ta_r;
    out_wt_nxt    = out_wt_r;

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          st_nxt = ST_FIN;
          if (in_mode == MODE_ARRIVE) begin
            if (q_full) begin
              res_pend_nxt = 1'b1;
              res_kind_nxt = KIND_DROP;
              res_id_nxt   = in_job_id;
              res_fin_nxt  = '0;
              res_ta_nxt   = '0;
              res_wt_nxt   = '0;
            end else begin
              count_nxt = count_r + CNT_W'(1);
            end
          end else begin
            if (run_done) begin
              // wait equals start minus arrival, turnaround adds the burst
              res_pend_nxt = 1'b1;
              res_kind_nxt = KIND_DONE;
              res_id_nxt   = run_id_r;
              res_fin_nxt  = time_r;
              res_ta_nxt   = run_wait_r + TW'(run_burst_r);
              res_wt_nxt   = run_wait_r;
              running_nxt  = 1'b0;
            end
            if ((!running_r || run_done) && (count_r != '0)) begin
              st_nxt       = ST_SCAN;
              scan_cnt_nxt = '0;
            end else begin
              time_nxt = time_r + TW'(1);
            end
          end
        end
      end
      ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + IDX_W'(1);
        if (scan_cnt_r == IDX_W'(QUEUE_DEPTH - 1)) begin
          st_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        run_id_nxt    = best_job.id;
        run_burst_nxt = best_job.burst;
        run_wait_nxt  = time_r - best_arr;
        run_end_nxt   = time_r + TW'(best_job.burst);
        running_nxt   = 1'b1;
        count_nxt     = count_r - CNT_W'(1);
        time_nxt      = time_r + TW'(1);
        st_nxt        = ST_FIN;
      end
      ST_FIN: begin
        if (!res_pend_r || out_free) begin
          if (res_pend_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = res_kind_r;
            out_id_nxt    = res_id_r;
            out_fin_nxt   = OUT_W'(res_fin_r);
            out_ta_nxt    = OUT_W'(res_ta_r);
            out_wt_nxt    = OUT_W'(res_wt_r);
          end
          res_pend_nxt = 1'b0;
          st_nxt       = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      count_r     <= '0;
      time_r      <= '0;
      running_r   <= 1'b0;
      scan_cnt_r  <= '0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      time_r      <= time_nxt;
      running_r   <= running_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      res_pend_r  <= res_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_id_r    <= run_id_nxt;
    run_burst_r <= run_burst_nxt;
    run_wait_r  <= run_wait_nxt;
    run_end_r   <= run_end_nxt;
    res_kind_r  <= res_kind_nxt;
    res_id_r    <= res_id_nxt;
    res_fin_r   <= res_fin_nxt;
    res_ta_r    <= res_ta_nxt;
    res_wt_r    <= res_wt_nxt;
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_fin_r   <= out_fin_nxt;
    out_ta_r    <= out_ta_nxt;
    out_wt_r    <= out_wt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_done_id     = out_id_r;
  assign out_finish_time = out_fin_r;
  assign out_turnaround  = out_ta_r;
  assign out_wait_ticks  = out_wt_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_scan_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) |-> ((count_r != '0) && !running_r))
    else $error("scan without a queued job or with a job running");

  a_commit_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_COMMIT) |=> (running_r && (count_r == $past(count_r) - CNT_W'(1))))
    else $error("commit did not start a job");

  // a completion found on a starting tick stays pending through scan and commit
  a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_pend_r |-> (st_r != ST_IDLE))
    else $error("result pending while idle");

  a_winner_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_COMMIT) |-> (tok_vld[QUEUE_DEPTH-1] &&
                             (CNT_W'(best_idx) < count_r)))
    else $error("chain produced no occupied winner");
`endif

endmodule
